@@ hw/rtl/ats_pkg.sv @@
// Shared types and constants for the 2D affine transform setup block.
package ats_pkg;

    localparam int CXW = 34;
    localparam int CZW = 34;
    localparam int ATAN_LEN = 24;

    localparam logic [14:0] FULL_TURN = 15'd23040;
    localparam logic [14:0] QUARTER_TURN = 15'd5760;
    localparam logic signed [CXW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [CZW-1:0] ATAN_DEG_Q24 [ATAN_LEN] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115
    };

    typedef struct packed {
        logic signed [15:0] angle_deg;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic signed [23:0] position_x;
        logic signed [23:0] position_y;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] m_xx;
        logic signed [23:0] m_xy;
        logic signed [23:0] m_yx;
        logic signed [23:0] m_yy;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
    } t_out_item;

    typedef struct packed {
        logic        [1:0]  quad;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic signed [23:0] px;
        logic signed [23:0] py;
    } t_pass;

endpackage

@@ hw/rtl/ats_stream_if.sv @@
// Valid/ready stream channel carrying one payload beat.
interface ats_stream_if #(parameter type T_DATA = logic);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/affine_transform_setup_2d_top.sv @@
// Affine transform setup: one beat in gives scale/rotate coefficients and
// saturated translations. Fully pipelined, one beat per cycle sustained while
// o_out is ready. There is one register stage per CORDIC iteration plus angle
// reduction, trig rounding, two coefficient stages and three translation
// stages. Each stage advances when its successor has room, so bubbles close
// up under output backpressure. No reset-time sweep.
module affine_transform_setup_2d_top import ats_pkg::*; #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ats_stream_if.sink    i_in,
    ats_stream_if.source  o_out
);

    localparam int NIT = TRIG_ITERATIONS;

    function automatic logic signed [23:0] sat_coef(input logic signed [25:0] v);
        logic signed [23:0] res;
        if (v > 26'sd8388607) begin
            res = 24'sh7FFFFF;
        end else if (v < -26'sd8388608) begin
            res = 24'sh800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    // stage 0 and cordic stages
    logic                  r_vc [NIT+1];
    logic signed [CXW-1:0] r_cx [NIT+1];
    logic signed [CXW-1:0] r_cy [NIT+1];
    logic signed [CZW-1:0] r_cz [NIT+1];
    t_pass                 r_cp [NIT+1];
    logic                  w_en_c [NIT+1];

    logic                 r_v_r, r_v_m1, r_v_m2, r_v_t1, r_v_t2, r_v_t3;
    logic                 w_en_r, w_en_m1, w_en_m2, w_en_t1, w_en_t2, w_en_t3;

    logic signed [17:0]   r_cs, r_sn;
    t_pass                r_pr;
    logic signed [33:0]   r_pxc, r_pyc, r_pxs, r_pys;
    t_pass                r_pm1;
    logic signed [24:0]   r_scx, r_scy, r_ssx, r_ssy;
    t_pass                r_pm2;
    logic signed [48:0]   r_pa, r_pb, r_pc, r_pd;
    t_pass                r_pt1;
    t_out_item            r_c1;
    logic signed [49:0]   r_tx, r_ty;
    t_out_item            r_c2;
    t_out_item            r_out;

    // stall chain
    assign w_en_t3 = !r_v_t3 || o_out.ready;
    assign w_en_t2 = !r_v_t2 || w_en_t3;
    assign w_en_t1 = !r_v_t1 || w_en_t2;
    assign w_en_m2 = !r_v_m2 || w_en_t1;
    assign w_en_m1 = !r_v_m1 || w_en_m2;
    assign w_en_r  = !r_v_r  || w_en_m1;
    assign w_en_c[NIT] = !r_vc[NIT] || w_en_r;

    assign i_in.ready  = w_en_c[0];
    assign o_out.valid = r_v_t3;
    assign o_out.data  = r_out;

    // angle reduction
    logic        [1:0]    n_quad;
    logic signed [CZW-1:0] n_z0;
    always_comb begin
        logic signed [16:0] a;
        logic signed [16:0] r;
        logic        [14:0] nn;
        logic        [14:0] res;
        a = 17'(i_in.data.angle_deg);
        if (a >= 17'sd23040) begin
            r = a - 17'sd23040;
        end else if (a >= 17'sd0) begin
            r = a;
        end else if (a >= -17'sd23040) begin
            r = a + 17'sd23040;
        end else begin
            r = a + 17'sd46080;
        end
        nn = (r == 17'sd0) ? 15'd0 : FULL_TURN - r[14:0];
        if (nn < QUARTER_TURN) begin
            n_quad = 2'd0;
            res = nn;
        end else if (nn < 15'(2 * QUARTER_TURN)) begin
            n_quad = 2'd1;
            res = nn - QUARTER_TURN;
        end else if (nn < 15'(3 * QUARTER_TURN)) begin
            n_quad = 2'd2;
            res = nn - 15'(2 * QUARTER_TURN);
        end else begin
            n_quad = 2'd3;
            res = nn - 15'(3 * QUARTER_TURN);
        end
        n_z0 = $signed(CZW'(res)) <<< 18;
    end

    if (NIT > 0) begin : g_en0
        assign w_en_c[0] = !r_vc[0] || w_en_c[1];
    end else begin : g_en0_direct
        assign w_en_c[0] = !r_vc[0] || w_en_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc[0] <= 1'b0;
        end else if (w_en_c[0]) begin
            r_vc[0] <= i_in.valid;
        end
        if (w_en_c[0]) begin
            r_cx[0]      <= CORDIC_GAIN;
            r_cy[0]      <= '0;
            r_cz[0]      <= n_z0;
            r_cp[0].quad <= n_quad;
            r_cp[0].sx   <= i_in.data.scale_x;
            r_cp[0].sy   <= i_in.data.scale_y;
            r_cp[0].ox   <= i_in.data.origin_x;
            r_cp[0].oy   <= i_in.data.origin_y;
            r_cp[0].px   <= i_in.data.position_x;
            r_cp[0].py   <= i_in.data.position_y;
        end
    end

    for (genvar gi = 0; gi < NIT; gi++) begin : g_cordic
        if (gi + 1 < NIT) begin : g_en
            assign w_en_c[gi+1] = !r_vc[gi+1] || w_en_c[gi+2];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vc[gi+1] <= 1'b0;
            end else if (w_en_c[gi+1]) begin
                r_vc[gi+1] <= r_vc[gi];
            end
            if (w_en_c[gi+1]) begin
                if (r_cz[gi] >= 0) begin
                    r_cx[gi+1] <= r_cx[gi] - (r_cy[gi] >>> gi);
                    r_cy[gi+1] <= r_cy[gi] + (r_cx[gi] >>> gi);
                    r_cz[gi+1] <= r_cz[gi] - ATAN_DEG_Q24[gi];
                end else begin
                    r_cx[gi+1] <= r_cx[gi] + (r_cy[gi] >>> gi);
                    r_cy[gi+1] <= r_cy[gi] - (r_cx[gi] >>> gi);
                    r_cz[gi+1] <= r_cz[gi] + ATAN_DEG_Q24[gi];
                end
                r_cp[gi+1] <= r_cp[gi];
            end
        end
    end

    // trig rounding, clamp, quadrant map
    logic signed [17:0] n_cs, n_sn;
    always_comb begin
        logic signed [CXW-1:0] xr, yr;
        logic signed [19:0]    xt, yt;
        logic signed [17:0]    c, s;
        xr = r_cx[NIT] + CXW'(8192);
        yr = r_cy[NIT] + CXW'(8192);
        xt = xr[33:14];
        yt = yr[33:14];
        c = (xt > 20'sd65536) ? 18'sd65536 : ((xt < -20'sd65536) ? -18'sd65536 : xt[17:0]);
        s = (yt > 20'sd65536) ? 18'sd65536 : ((yt < -20'sd65536) ? -18'sd65536 : yt[17:0]);
        case (r_cp[NIT].quad)
            2'd0: begin n_cs = c;  n_sn = s;  end
            2'd1: begin n_cs = -s; n_sn = c;  end
            2'd2: begin n_cs = -c; n_sn = -s; end
            default: begin n_cs = s; n_sn = -c; end
        endcase
    end

    // coefficient products and rounding
    logic signed [24:0] n_scx, n_scy, n_ssx, n_ssy;
    always_comb begin
        logic signed [33:0] rxc, ryc, rxs, rys;
        rxc = r_pxc + 34'sd128;
        ryc = r_pyc + 34'sd128;
        rxs = r_pxs + 34'sd128;
        rys = r_pys + 34'sd128;
        n_scx = rxc[32:8];
        n_scy = ryc[32:8];
        n_ssx = rxs[32:8];
        n_ssy = rys[32:8];
    end

    // translation sums, rounding and saturation
    logic signed [49:0] n_tx, n_ty;
    logic signed [31:0] n_shx, n_shy;
    always_comb begin
        logic signed [49:0] pxw, pyw, rx, ry;
        logic signed [33:0] vx, vy;
        pxw = 50'(r_pt1.px) <<< 16;
        pyw = 50'(r_pt1.py) <<< 16;
        n_tx = pxw - 50'(r_pa) - 50'(r_pb);
        n_ty = pyw + 50'(r_pc) - 50'(r_pd);
        rx = r_tx + 50'sd32768;
        ry = r_ty + 50'sd32768;
        vx = rx[49:16];
        vy = ry[49:16];
        n_shx = (vx > 34'sd2147483647) ? 32'sh7FFFFFFF :
                ((vx < -34'sd2147483648) ? 32'sh80000000 : vx[31:0]);
        n_shy = (vy > 34'sd2147483647) ? 32'sh7FFFFFFF :
                ((vy < -34'sd2147483648) ? 32'sh80000000 : vy[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_r  <= 1'b0;
            r_v_m1 <= 1'b0;
            r_v_m2 <= 1'b0;
            r_v_t1 <= 1'b0;
            r_v_t2 <= 1'b0;
            r_v_t3 <= 1'b0;
        end else begin
            if (w_en_r)  r_v_r  <= r_vc[NIT];
            if (w_en_m1) r_v_m1 <= r_v_r;
            if (w_en_m2) r_v_m2 <= r_v_m1;
            if (w_en_t1) r_v_t1 <= r_v_m2;
            if (w_en_t2) r_v_t2 <= r_v_t1;
            if (w_en_t3) r_v_t3 <= r_v_t2;
        end
        if (w_en_r) begin
            r_cs <= n_cs;
            r_sn <= n_sn;
            r_pr <= r_cp[NIT];
        end
        if (w_en_m1) begin
            r_pxc <= 34'(r_pr.sx) * 34'(r_cs);
            r_pyc <= 34'(r_pr.sy) * 34'(r_cs);
            r_pxs <= 34'(r_pr.sx) * 34'(r_sn);
            r_pys <= 34'(r_pr.sy) * 34'(r_sn);
            r_pm1 <= r_pr;
        end
        if (w_en_m2) begin
            r_scx <= n_scx;
            r_scy <= n_scy;
            r_ssx <= n_ssx;
            r_ssy <= n_ssy;
            r_pm2 <= r_pm1;
        end
        if (w_en_t1) begin
            r_pa         <= 49'(r_pm2.ox) * 49'(r_scx);
            r_pb         <= 49'(r_pm2.oy) * 49'(r_ssy);
            r_pc         <= 49'(r_pm2.ox) * 49'(r_ssx);
            r_pd         <= 49'(r_pm2.oy) * 49'(r_scy);
            r_pt1        <= r_pm2;
            r_c1.m_xx    <= sat_coef(26'(r_scx));
            r_c1.m_xy    <= sat_coef(26'(r_ssy));
            r_c1.m_yx    <= sat_coef(-26'(r_ssx));
            r_c1.m_yy    <= sat_coef(26'(r_scy));
            r_c1.shift_x <= '0;
            r_c1.shift_y <= '0;
        end
        if (w_en_t2) begin
            r_tx <= n_tx;
            r_ty <= n_ty;
            r_c2 <= r_c1;
        end
        if (w_en_t3) begin
            r_out.m_xx    <= r_c2.m_xx;
            r_out.m_xy    <= r_c2.m_xy;
            r_out.m_yx    <= r_c2.m_yx;
            r_out.m_yy    <= r_c2.m_yy;
            r_out.shift_x <= n_shx;
            r_out.shift_y <= n_shy;
        end
    end

    // input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready && r_v_t1 && r_vc[0]))
        else $error("input stalled with room in the pipeline");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vc[0])
        else $error("accepted beat not captured");

    a_residue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc[0] |-> (r_cz[0] >= 0 && r_cz[0] < (CZW'(QUARTER_TURN) <<< 18)))
        else $error("angle residue outside one quadrant");

    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_r |-> (r_cs <= 18'sd65536 && r_cs >= -18'sd65536 &&
                   r_sn <= 18'sd65536 && r_sn >= -18'sd65536))
        else $error("trig value beyond unit range");

endmodule
